[hdl/lzrdc_pkg.sv]
// ----------------------------------------------------------------------------
// LZSS ring decoder package
// Shared widths, codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lzrdc_pkg;

  localparam int WIN_DEPTH  = 4096;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int FILL_W     = WIN_AW + 1;
  localparam int BYTE_W     = 8;
  localparam int PLEN_W     = 29;
  localparam int OLEN_W     = 31;
  localparam int SUM_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEN = CFG_IDX_W'(1);

  // Reset values of the configuration registers.
  localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(5);
  localparam logic [OLEN_W-1:0] OLEN_RESET = OLEN_W'(1);

  // Final status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_OVERRUN   = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_EXTRA     = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_BAD_SUM   = STATUS_W'(4);

  // Value of a window byte that has not been written since the restart.
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LOW,
    PH_HIGH,
    PH_TAIL
  } phase_e;

  // What the byte under execution asks for.
  typedef enum logic [1:0] {
    ACT_QUIET,
    ACT_STATUS,
    ACT_LITERAL,
    ACT_MATCH
  } act_e;

  typedef struct packed {
    logic load;  // latch the accepted input byte
    logic exec;  // commit the decision for the latched byte
    logic rd;    // read the next copy source byte
    logic wr;    // write and emit the copy byte that was read
    logic done;  // close the current flag item
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic out_free;
    logic copy_last;
  } stat_t;

endpackage

[hdl/lzrdc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzrdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/lzrdc_ctrl.sv]
// ----------------------------------------------------------------------------
// LZSS decoder controller
// Sequences accept, execute, copy read/write and item close for each byte.
// ----------------------------------------------------------------------------
module lzrdc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            idle_o,
  input  lzrdc_pkg::stat_t stat_i,
  output lzrdc_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   needs_out;

  assign needs_out = (stat_i.act == lzrdc_pkg::ACT_STATUS) ||
                     (stat_i.act == lzrdc_pkg::ACT_LITERAL);

  // No item is under execution.
  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // A literal or status byte waits here until the output register frees up.
        if (!needs_out || stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          unique case (stat_i.act)
            lzrdc_pkg::ACT_LITERAL: state_d = S_DONE;
            lzrdc_pkg::ACT_MATCH:   state_d = S_RD;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        if (stat_i.out_free) begin
          cmd_o.wr = 1'b1;
          state_d  = stat_i.copy_last ? S_DONE : S_RD;
        end
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/lzrdc_dp.sv]
// ----------------------------------------------------------------------------
// LZSS decoder datapath
// Decode state, configuration, window memory, checksum and output register.
// ----------------------------------------------------------------------------
module lzrdc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [lzrdc_pkg::BYTE_W-1:0]         in_byte_i,
  input  logic                                 cfg_we_i,
  input  logic [lzrdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lzrdc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  lzrdc_pkg::cmd_t                      cmd_i,
  output lzrdc_pkg::stat_t                     stat_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lzrdc_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                                 out_is_status_o,
  output logic [lzrdc_pkg::STATUS_W-1:0]       out_status_o,
  output logic                                 out_last_o
);

  localparam int BW = lzrdc_pkg::BYTE_W;
  localparam int AW = lzrdc_pkg::WIN_AW;
  localparam int FW = lzrdc_pkg::FILL_W;
  localparam int PW = lzrdc_pkg::PLEN_W;
  localparam int OW = lzrdc_pkg::OLEN_W;
  localparam int SW = lzrdc_pkg::SUM_W;
  localparam int CW = lzrdc_pkg::COUNT_W;

  // Configuration.
  logic [PW-1:0] packed_len_q, packed_len_d;
  logic [OW-1:0] output_len_q, output_len_d;

  // Decode state.
  lzrdc_pkg::phase_e phase_q, phase_d;
  logic [15:0]   flag_q, flag_d;
  logic [BW-1:0] low_hold_q, low_hold_d;
  logic [PW-1:0] bytes_in_q, bytes_in_d;
  logic [OW-1:0] bytes_out_q, bytes_out_d;
  logic [SW-1:0] run_sum_q, run_sum_d;
  logic [SW-1:0] stored_sum_q, stored_sum_d;
  logic          finished_q, finished_d;
  logic [AW-1:0] write_pos_q, write_pos_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] src_q, src_d;
  logic [CW-1:0] copy_left_q, copy_left_d;
  logic          rd_hit_q, rd_hit_d;
  logic [BW-1:0] byte_q;

  // Output register.
  logic                             out_valid_q, out_valid_d;
  logic [BW-1:0]                    out_byte_q, out_byte_d;
  logic                             out_is_status_q, out_is_status_d;
  logic [lzrdc_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic                             out_last_q, out_last_d;

  // Window memory port.
  logic          ram_we;
  logic [BW-1:0] ram_wdata;
  logic          ram_re;
  logic [BW-1:0] ram_rdata;

  // Decision for the latched byte.
  lzrdc_pkg::act_e                act;
  logic [lzrdc_pkg::STATUS_W-1:0] st_code;
  logic          cfg_bad;
  logic [PW-1:0] end_w;
  logic          exhausted;
  logic [AW-1:0] copy_dist;
  logic [CW-1:0] count;
  logic [OW-1:0] remain;
  logic [SW-1:0] new_stored;
  logic          sum_end;
  logic          out_free;
  logic [15:0]   flag_next;

  // Produced byte.
  logic          prod;
  logic [BW-1:0] prod_byte;
  logic          prod_last;

  assign cfg_bad = (packed_len_q < lzrdc_pkg::PLEN_RESET) || (output_len_q == '0) ||
                   (output_len_q > (OW'(1) << 30));
  assign end_w      = packed_len_q - PW'(4);
  assign exhausted  = bytes_in_q >= end_w;
  assign copy_dist  = {byte_q[7:4], low_hold_q};
  assign count      = CW'(byte_q[3:0]) + CW'(3);
  assign remain     = output_len_q - bytes_out_q;
  assign new_stored = {byte_q, stored_sum_q[SW-1:BW]};
  assign sum_end    = ({1'b0, bytes_in_q} + (PW+1)'(1)) >= {1'b0, packed_len_q};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign flag_next  = flag_q >> 1;

  always_comb begin
    act     = lzrdc_pkg::ACT_QUIET;
    st_code = lzrdc_pkg::ST_OK;
    priority if (finished_q) begin
      act = lzrdc_pkg::ACT_QUIET;
    end else if (cfg_bad) begin
      act     = lzrdc_pkg::ACT_STATUS;
      st_code = lzrdc_pkg::ST_EXHAUSTED;
    end else if (phase_q != lzrdc_pkg::PH_TAIL) begin
      if (exhausted) begin
        act     = lzrdc_pkg::ACT_STATUS;
        st_code = lzrdc_pkg::ST_EXHAUSTED;
      end else begin
        unique case (phase_q)
          lzrdc_pkg::PH_LOW: begin
            act = flag_q[0] ? lzrdc_pkg::ACT_LITERAL : lzrdc_pkg::ACT_QUIET;
          end
          lzrdc_pkg::PH_HIGH: begin
            if (OW'(count) > remain) begin
              act     = lzrdc_pkg::ACT_STATUS;
              st_code = lzrdc_pkg::ST_OVERRUN;
            end else begin
              act = lzrdc_pkg::ACT_MATCH;
            end
          end
          default: act = lzrdc_pkg::ACT_QUIET;
        endcase
      end
    end else if (!exhausted) begin
      act     = lzrdc_pkg::ACT_STATUS;
      st_code = lzrdc_pkg::ST_EXTRA;
    end else if (sum_end) begin
      act     = lzrdc_pkg::ACT_STATUS;
      st_code = (run_sum_q == new_stored) ? lzrdc_pkg::ST_OK : lzrdc_pkg::ST_BAD_SUM;
    end else begin
      act = lzrdc_pkg::ACT_QUIET;
    end
  end

  assign stat_o.act       = act;
  assign stat_o.out_free  = out_free;
  assign stat_o.copy_last = (copy_left_q == CW'(1));

  always_comb begin
    packed_len_d    = packed_len_q;
    output_len_d    = output_len_q;
    phase_d         = phase_q;
    flag_d          = flag_q;
    low_hold_d      = low_hold_q;
    bytes_in_d      = bytes_in_q;
    bytes_out_d     = bytes_out_q;
    run_sum_d       = run_sum_q;
    stored_sum_d    = stored_sum_q;
    finished_d      = finished_q;
    write_pos_d     = write_pos_q;
    fill_d          = fill_q;
    src_d           = src_q;
    copy_left_d     = copy_left_q;
    rd_hit_d        = rd_hit_q;
    out_valid_d     = out_valid_q;
    out_byte_d      = out_byte_q;
    out_is_status_d = out_is_status_q;
    out_status_d    = out_status_q;
    out_last_d      = out_last_q;
    ram_re          = 1'b0;
    prod            = 1'b0;
    prod_byte       = byte_q;
    prod_last       = 1'b1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.exec) begin
      unique case (act)
        lzrdc_pkg::ACT_STATUS: begin
          finished_d      = 1'b1;
          out_valid_d     = 1'b1;
          out_byte_d      = '0;
          out_is_status_d = 1'b1;
          out_status_d    = st_code;
          out_last_d      = 1'b1;
        end
        lzrdc_pkg::ACT_LITERAL: begin
          prod = 1'b1;
        end
        lzrdc_pkg::ACT_MATCH: begin
          src_d       = write_pos_q - copy_dist;
          copy_left_d = count;
        end
        default: ;
      endcase
      // Bookkeeping that does not depend on the emitted result.
      if (!finished_q && !cfg_bad && !exhausted) begin
        if (phase_q != lzrdc_pkg::PH_TAIL) begin
          bytes_in_d = bytes_in_q + PW'(1);
          unique case (phase_q)
            lzrdc_pkg::PH_FLAG: begin
              flag_d  = {8'hff, byte_q};
              phase_d = lzrdc_pkg::PH_LOW;
            end
            lzrdc_pkg::PH_LOW: begin
              if (!flag_q[0]) begin
                low_hold_d = byte_q;
                phase_d    = lzrdc_pkg::PH_HIGH;
              end
            end
            default: ;
          endcase
        end
      end else if (!finished_q && !cfg_bad && phase_q == lzrdc_pkg::PH_TAIL) begin
        stored_sum_d = new_stored;
        bytes_in_d   = bytes_in_q + PW'(1);
      end
    end

    if (cmd_i.rd) begin
      ram_re   = 1'b1;
      src_d    = src_q + AW'(1);
      rd_hit_d = {1'b0, src_q} < fill_q;
    end

    if (cmd_i.wr) begin
      prod        = 1'b1;
      prod_byte   = rd_hit_q ? ram_rdata : lzrdc_pkg::FILL_BYTE;
      prod_last   = (copy_left_q == CW'(1));
      copy_left_d = copy_left_q - CW'(1);
    end

    if (prod) begin
      write_pos_d     = write_pos_q + AW'(1);
      if (fill_q != FW'(lzrdc_pkg::WIN_DEPTH)) begin
        fill_d = fill_q + FW'(1);
      end
      run_sum_d       = run_sum_q + SW'(prod_byte);
      bytes_out_d     = bytes_out_q + OW'(1);
      out_valid_d     = 1'b1;
      out_byte_d      = prod_byte;
      out_is_status_d = 1'b0;
      out_status_d    = lzrdc_pkg::ST_OK;
      out_last_d      = prod_last;
    end

    if (cmd_i.done) begin
      if (bytes_out_q >= output_len_q) begin
        phase_d = lzrdc_pkg::PH_TAIL;
      end else begin
        flag_d  = flag_next;
        phase_d = flag_next[8] ? lzrdc_pkg::PH_LOW : lzrdc_pkg::PH_FLAG;
      end
    end

    // A write to a defined register restarts the member.
    if (cfg_we_i && (cfg_index_i == lzrdc_pkg::CFG_PACKED_LEN ||
                     cfg_index_i == lzrdc_pkg::CFG_OUTPUT_LEN)) begin
      if (cfg_index_i == lzrdc_pkg::CFG_PACKED_LEN) begin
        packed_len_d = cfg_data_i[PW-1:0];
      end else begin
        output_len_d = cfg_data_i[OW-1:0];
      end
      phase_d      = lzrdc_pkg::PH_FLAG;
      flag_d       = '0;
      low_hold_d   = '0;
      bytes_in_d   = '0;
      bytes_out_d  = '0;
      run_sum_d    = '0;
      stored_sum_d = '0;
      finished_d   = 1'b0;
      write_pos_d  = '0;
      fill_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packed_len_q <= lzrdc_pkg::PLEN_RESET;
      output_len_q <= lzrdc_pkg::OLEN_RESET;
      phase_q      <= lzrdc_pkg::PH_FLAG;
      flag_q       <= '0;
      low_hold_q   <= '0;
      bytes_in_q   <= '0;
      bytes_out_q  <= '0;
      run_sum_q    <= '0;
      stored_sum_q <= '0;
      finished_q   <= 1'b0;
      write_pos_q  <= '0;
      fill_q       <= '0;
      copy_left_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      packed_len_q <= packed_len_d;
      output_len_q <= output_len_d;
      phase_q      <= phase_d;
      flag_q       <= flag_d;
      low_hold_q   <= low_hold_d;
      bytes_in_q   <= bytes_in_d;
      bytes_out_q  <= bytes_out_d;
      run_sum_q    <= run_sum_d;
      stored_sum_q <= stored_sum_d;
      finished_q   <= finished_d;
      write_pos_q  <= write_pos_d;
      fill_q       <= fill_d;
      copy_left_q  <= copy_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_byte_i;
    end
    src_q           <= src_d;
    rd_hit_q        <= rd_hit_d;
    out_byte_q      <= out_byte_d;
    out_is_status_q <= out_is_status_d;
    out_status_q    <= out_status_d;
    out_last_q      <= out_last_d;
  end

  assign ram_we    = prod;
  assign ram_wdata = prod_byte;

  lzrdc_ram #(
    .WIDTH(BW),
    .DEPTH(lzrdc_pkg::WIN_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(write_pos_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(src_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_is_status_o = out_is_status_q;
  assign out_status_o    = out_status_q;
  assign out_last_o      = out_last_q;

endmodule

[hdl/lzss_ring_decoder_checksum_core.sv]
// ----------------------------------------------------------------------------
// LZSS ring decoder with additive checksum
// Decodes one LZSS member a byte at a time and checks its trailing sum.
// ----------------------------------------------------------------------------
// The block takes one packed byte per item and handles one item at a time.
// A flag byte, the low byte of a back-reference, a checksum byte or an item
// with a status result is accepted and executed, and a literal is then also
// closed. A back-reference high byte starts a copy: each copied byte is read
// from the 4096-byte window memory and then written back and handed to the
// output register, and the item is closed after the last one. The window is
// not swept after reset or a configuration write: a fill count marks which
// entries have been written since the restart, and any other entry reads as
// a space, so the block accepts items right away. Results leave through an
// output register, so a waiting result does not block the next input item
// unless that item itself has a result to hand over. After a status result
// every input item is accepted and dropped until the next configuration
// write. Configuration writes are taken only while no item is being
// executed; a write to register 0 or 1 restarts the member.
module lzss_ring_decoder_checksum_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [lzrdc_pkg::BYTE_W-1:0]         in_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lzrdc_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                                 out_is_status_o,
  output logic [lzrdc_pkg::STATUS_W-1:0]       out_status_o,
  output logic                                 out_last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lzrdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lzrdc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  lzrdc_pkg::cmd_t  cmd;
  lzrdc_pkg::stat_t stat;
  logic             ctrl_idle;

  // Registers are written only while the decoder is idle.
  assign cfg_ready_o = ctrl_idle;

  lzrdc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .idle_o    (ctrl_idle),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lzrdc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_byte_i      (in_byte_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_is_status_o(out_is_status_o),
    .out_status_o   (out_status_o),
    .out_last_o     (out_last_o)
  );

`ifndef SYNTHESIS
  // A copy byte is only committed when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> stat.out_free)
    else $error("copy byte committed while output register is blocked");

  // An accepted item holds off the next one while it executes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item accepted while the first is executing");

  // A status result always closes the results of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_is_status_o) |-> out_last_o)
    else $error("status result without last");

  // A back-reference starts its copy with a window read right away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec && stat.act == lzrdc_pkg::ACT_MATCH) |=> cmd.rd)
    else $error("back-reference did not start its copy");
`endif

endmodule
